@@ rtl/irq_redirection_router_top_defines.svh @@
// assertion macros shared by the irq redirection router rtl
// no dependencies; pulled in by the files that carry assertions
`ifndef IRQ_REDIRECTION_ROUTER_TOP_DEFINES_SVH
`define IRQ_REDIRECTION_ROUTER_TOP_DEFINES_SVH

// condition must never hold out of reset
`define IRP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define IRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/irp_pkg.sv @@
// types, codes and helpers for the irq redirection router
// no dependencies; used by every module of the block
package irp_pkg;

  localparam logic [2:0] OP_LOAD     = 3'd0;
  localparam logic [2:0] OP_CONFIG   = 3'd1;
  localparam logic [2:0] OP_MASK     = 3'd2;
  localparam logic [2:0] OP_UNMASK   = 3'd3;
  localparam logic [2:0] OP_MASK_ALL = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_OOR  = 2'd2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_GSI = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_ID  = 1'b1;

  localparam int DEF_OVERRIDE_SLOTS = 16;
  localparam int DEF_REDIR_ENTRIES  = 24;
  localparam int QUEUE_DEPTH        = 2;

  localparam int MASK_BIT   = 16;
  localparam int LEVEL_BIT  = 15;
  localparam int LOW_BIT    = 13;
  localparam int DEST_SHIFT = 56;
  localparam logic [7:0] VEC_BASE = 8'd32;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  irq_number;
    logic [31:0] override_gsi;
    logic [15:0] override_flags;
    logic        restart_list;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  table_index;
    logic [63:0] entry_value;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  src;
    logic [31:0] gsi;
    logic [3:0]  flags;
  } ovr_slot_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] irq;
    logic [7:0] tindex;
    logic       oor;
    logic [3:0] flags;
    logic [1:0] status;
  } cmd_t;

  function automatic logic [63:0] make_entry(input logic [7:0] irq,
                                             input logic [3:0] flags,
                                             input logic [7:0] dest);
    logic [63:0] e;
    e = '0;
    e[7:0] = irq + VEC_BASE;
    e[LOW_BIT] = (flags[1:0] == 2'b11);
    e[LEVEL_BIT] = (flags[3:2] == 2'b11);
    e[MASK_BIT] = 1'b1;
    e[DEST_SHIFT +: 8] = dest;
    return e;
  endfunction

endpackage

@@ rtl/irp_front.sv @@
// front end: accepts requests, keeps the override table, resolves the entry index
// depends on irp_pkg and the assertion macro header
`include "irq_redirection_router_top_defines.svh"

module irp_front #(
  parameter int OVERRIDE_SLOTS = irp_pkg::DEF_OVERRIDE_SLOTS,
  parameter int REDIR_ENTRIES  = irp_pkg::DEF_REDIR_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  irp_pkg::in_item_t in_data,
  input  logic [31:0]       base_gsi,
  output logic              q_push,
  output irp_pkg::cmd_t     q_data,
  input  logic              q_full
);

  localparam int SLOT_W = (OVERRIDE_SLOTS > 1) ? $clog2(OVERRIDE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(OVERRIDE_SLOTS + 1);

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_SCAN = 2'd1;
  localparam logic [1:0] FS_PUSH = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]   scan_r, scan_nxt;
  logic               pend_r, pend_nxt;
  irp_pkg::in_item_t  item_r;
  irp_pkg::cmd_t      cmd_r, cmd_nxt;
  logic               cmd_load;
  irp_pkg::ovr_slot_t ovr_mem [OVERRIDE_SLOTS];
  irp_pkg::ovr_slot_t rd_data_r;

  logic             in_acc;
  logic [CNT_W-1:0] used_base;
  logic             load_fits;
  logic             hit, miss, rd_issue;
  logic [31:0]      idx32;

  assign in_acc    = in_valid && (state_r == FS_IDLE);
  assign in_stall  = (state_r != FS_IDLE);
  assign used_base = in_data.restart_list ? '0 : used_r;
  assign load_fits = (used_base < CNT_W'(OVERRIDE_SLOTS));

  // one slot read per cycle, compared the cycle after
  assign hit      = (state_r == FS_SCAN) && pend_r && (rd_data_r.src == item_r.irq_number);
  assign rd_issue = (state_r == FS_SCAN) && !hit && (scan_r < used_r);
  assign miss     = (state_r == FS_SCAN) && !pend_r && !(scan_r < used_r);

  // without an override the index is just the irq number
  assign idx32 = hit ? (rd_data_r.gsi - base_gsi) : {24'd0, item_r.irq_number};

  always_ff @(posedge clk) begin
    if (in_acc && (in_data.op == irp_pkg::OP_LOAD) && load_fits) begin
      ovr_mem[used_base[SLOT_W-1:0]] <= '{src:   in_data.irq_number,
                                          gsi:   in_data.override_gsi,
                                          flags: in_data.override_flags[3:0]};
    end
    if (rd_issue) begin
      rd_data_r <= ovr_mem[scan_r[SLOT_W-1:0]];
    end
  end

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    scan_nxt  = scan_r;
    pend_nxt  = pend_r;
    cmd_nxt   = cmd_r;
    cmd_load  = 1'b0;
    unique case (state_r)
      FS_IDLE: begin
        if (in_acc) begin
          scan_nxt       = '0;
          pend_nxt       = 1'b0;
          cmd_load       = 1'b1;
          cmd_nxt.op     = in_data.op;
          cmd_nxt.irq    = in_data.irq_number;
          cmd_nxt.tindex = '0;
          cmd_nxt.oor    = 1'b0;
          cmd_nxt.flags  = '0;
          cmd_nxt.status = irp_pkg::ST_OK;
          unique case (in_data.op) inside
            irp_pkg::OP_LOAD: begin
              state_nxt = FS_PUSH;
              if (load_fits) begin
                used_nxt = CNT_W'(used_base + 1'b1);
              end else begin
                used_nxt       = used_base;
                cmd_nxt.status = irp_pkg::ST_DROP;
              end
            end
            irp_pkg::OP_CONFIG, irp_pkg::OP_MASK, irp_pkg::OP_UNMASK: begin
              state_nxt = FS_SCAN;
            end
            default: begin
              state_nxt = FS_PUSH;
            end
          endcase
        end
      end
      FS_SCAN: begin
        if (hit || miss) begin
          cmd_load       = 1'b1;
          cmd_nxt.tindex = idx32[7:0];
          cmd_nxt.oor    = (idx32 >= 32'(REDIR_ENTRIES));
          cmd_nxt.flags  = hit ? rd_data_r.flags : 4'd0;
          state_nxt      = FS_PUSH;
        end else if (rd_issue) begin
          scan_nxt = CNT_W'(scan_r + 1'b1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      FS_PUSH: begin
        if (!q_full) begin
          state_nxt = FS_IDLE;
        end
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      used_r  <= '0;
      scan_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      scan_r  <= scan_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    if (cmd_load) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign q_push = (state_r == FS_PUSH) && !q_full;
  assign q_data = cmd_r;

  `IRP_ASSERT_NEVER(a_used_bound, clk, rst_n, used_r > CNT_W'(OVERRIDE_SLOTS), "override count past slot count")
  `IRP_ASSERT_NEXT(a_restart_one, clk, rst_n, in_acc && (in_data.op == irp_pkg::OP_LOAD) && in_data.restart_list, used_r == CNT_W'(1), "restart load did not leave one override")

endmodule

@@ rtl/irp_queue.sv @@
// short request queue between front and back
// depends on irp_pkg and the assertion macro header
`include "irq_redirection_router_top_defines.svh"

module irp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  irp_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output irp_pkg::cmd_t pop_data,
  output logic          empty
);

  localparam int QP_W = (irp_pkg::QUEUE_DEPTH > 1) ? $clog2(irp_pkg::QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(irp_pkg::QUEUE_DEPTH + 1);

  irp_pkg::cmd_t   q_mem [irp_pkg::QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0] cnt_r;

  assign full     = (cnt_r == QC_W'(irp_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = q_mem[rd_ptr_r];

  function automatic logic [QP_W-1:0] ptr_inc(input logic [QP_W-1:0] p);
    return (p == QP_W'(irp_pkg::QUEUE_DEPTH - 1)) ? '0 : QP_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= QC_W'(cnt_r + 1'b1);
      end else if (pop && !push) begin
        cnt_r <= QC_W'(cnt_r - 1'b1);
      end
    end
  end

  `IRP_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full, "push into full queue")
  `IRP_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, !empty, "pop from empty queue")

endmodule

@@ rtl/irp_back.sv @@
// back end: redirection table updates and the result register
// depends on irp_pkg and the assertion macro header
`include "irq_redirection_router_top_defines.svh"

module irp_back #(
  parameter int REDIR_ENTRIES = irp_pkg::DEF_REDIR_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               q_pop,
  input  irp_pkg::cmd_t      q_data,
  input  logic [7:0]         dest_id,
  output logic               out_valid,
  input  logic               out_stall,
  output irp_pkg::out_item_t out_data
);

  localparam int IDX_W = (REDIR_ENTRIES > 1) ? $clog2(REDIR_ENTRIES) : 1;

  localparam logic BS_IDLE = 1'b0;
  localparam logic BS_READ = 1'b1;

  logic                     state_r, state_nxt;
  logic [REDIR_ENTRIES-1:0] vld_r;
  logic [REDIR_ENTRIES-1:0] mask_r;
  logic                     out_valid_r;
  irp_pkg::out_item_t       out_data_r;
  irp_pkg::cmd_t            cmd_r;
  logic [63:0]              entry_mem [REDIR_ENTRIES];
  logic [63:0]              rd_data_r;
  logic                     rd_vld_r, rd_mask_r;

  logic               out_free, start;
  logic               produce, go_read, cfg_wr, mask_set, clr_mask, mask_all;
  irp_pkg::out_item_t res;
  logic [63:0]        new_entry, base_entry;
  logic [IDX_W-1:0]   idx, ridx;

  assign out_free  = !out_valid_r || !out_stall;
  assign start     = (state_r == BS_IDLE) && !q_empty && out_free;
  assign q_pop     = start;
  assign idx       = q_data.tindex[IDX_W-1:0];
  assign ridx      = cmd_r.tindex[IDX_W-1:0];
  assign new_entry = irp_pkg::make_entry(q_data.irq, q_data.flags, dest_id);

  // never-written entries read as their reset value; mask bit lives in flops
  always_comb begin
    base_entry = rd_vld_r ? rd_data_r : 64'd0;
    base_entry[irp_pkg::MASK_BIT] = rd_mask_r;
  end

  always_comb begin
    state_nxt = state_r;
    produce   = 1'b0;
    go_read   = 1'b0;
    cfg_wr    = 1'b0;
    mask_set  = 1'b0;
    clr_mask  = 1'b0;
    mask_all  = 1'b0;
    res       = '0;
    unique case (state_r)
      BS_IDLE: begin
        if (start) begin
          case (q_data.op) inside
            irp_pkg::OP_LOAD: begin
              produce    = 1'b1;
              res.status = q_data.status;
            end
            irp_pkg::OP_CONFIG, irp_pkg::OP_MASK, irp_pkg::OP_UNMASK: begin
              if (q_data.oor) begin
                produce         = 1'b1;
                res.status      = irp_pkg::ST_OOR;
                res.table_index = q_data.tindex;
              end else if (q_data.op == irp_pkg::OP_CONFIG) begin
                produce         = 1'b1;
                cfg_wr          = 1'b1;
                res.status      = irp_pkg::ST_OK;
                res.table_index = q_data.tindex;
                res.entry_value = new_entry;
              end else begin
                go_read   = 1'b1;
                state_nxt = BS_READ;
              end
            end
            irp_pkg::OP_MASK_ALL: begin
              produce  = 1'b1;
              mask_all = 1'b1;
            end
            default: begin
              produce = 1'b1;
            end
          endcase
        end
      end
      BS_READ: begin
        produce         = 1'b1;
        res.status      = irp_pkg::ST_OK;
        res.table_index = cmd_r.tindex;
        res.entry_value = base_entry;
        if (cmd_r.op == irp_pkg::OP_MASK) begin
          res.entry_value[irp_pkg::MASK_BIT] = 1'b1;
          mask_set = 1'b1;
        end else begin
          res.entry_value[irp_pkg::MASK_BIT] = 1'b0;
          clr_mask = 1'b1;
        end
        state_nxt = BS_IDLE;
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cfg_wr) begin
      entry_mem[idx] <= new_entry;
    end
    if (go_read) begin
      rd_data_r <= entry_mem[idx];
      rd_vld_r  <= vld_r[idx];
      rd_mask_r <= mask_r[idx];
      cmd_r     <= q_data;
    end
    if (produce) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      vld_r       <= '0;
      mask_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mask_all) begin
        mask_r <= '1;
      end
      if (cfg_wr) begin
        vld_r[idx]  <= 1'b1;
        mask_r[idx] <= 1'b1;
      end
      if (mask_set) begin
        mask_r[ridx] <= 1'b1;
      end
      if (clr_mask) begin
        mask_r[ridx] <= 1'b0;
      end
      if (produce) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IRP_ASSERT_IMPLY(a_read_slot_free, clk, rst_n, state_r == BS_READ, !out_valid_r, "result register busy during entry read")

endmodule

@@ rtl/irq_redirection_router_top.sv @@
// top level of the irq redirection router: config registers, front, queue, back
// depends on irp_pkg, irp_front, irp_queue and irp_back
//
// Usage: requests enter on in_valid/in_stall/in_data, one result leaves per
// request on out_valid/out_stall/out_data; a transfer happens on a clock edge
// with valid high and stall low. The base gsi and the destination id are written
// through cfg_we/cfg_index/cfg_wdata while the block is idle.
// Loads, mask-all and unknown ops skip the override scan. Configure, mask and
// unmask scan the override table one slot per cycle, stopping at the first
// match or after the last override loaded; mask and unmask then add an entry
// read in the back. The front takes a new request once the previous one is
// queued; the back drains the two-entry queue independently.
// Reset: overrides are emptied, every redirection entry reads as masked with
// all other bits zero, both config registers clear. No clearing pass.
// Stall: a result waits in the output register while out_stall is high; the
// queue fills, then the front holds in_stall high.
module irq_redirection_router_top #(
  parameter int OVERRIDE_SLOTS = irp_pkg::DEF_OVERRIDE_SLOTS,
  parameter int REDIR_ENTRIES  = irp_pkg::DEF_REDIR_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  irp_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output irp_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [irp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [31:0]   base_gsi_r;
  logic [7:0]    dest_id_r;
  logic          q_push, q_full, q_pop, q_empty;
  irp_pkg::cmd_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_gsi_r <= '0;
      dest_id_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        irp_pkg::CFG_BASE_GSI: base_gsi_r <= cfg_wdata[31:0];
        irp_pkg::CFG_DEST_ID:  dest_id_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  irp_front #(
    .OVERRIDE_SLOTS (OVERRIDE_SLOTS),
    .REDIR_ENTRIES  (REDIR_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .base_gsi (base_gsi_r),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  irp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  irp_back #(
    .REDIR_ENTRIES (REDIR_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .dest_id   (dest_id_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
